// ----- src/rorf_pkg.sv -----
`timescale 1ns / 1ps
package rorf_pkg;

  // Table geometry
  localparam int unsigned MaxRoomSlots = 128;
  localparam int unsigned IdxW         = (MaxRoomSlots > 1) ? $clog2(MaxRoomSlots) : 1;
  localparam int unsigned CntW         = $clog2(MaxRoomSlots + 1);
  localparam int unsigned OutIdxW      = 7;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // One stored room, x in the low byte
  typedef struct packed {
    logic [7:0] h;
    logic [7:0] w;
    logic [7:0] y;
    logic [7:0] x;
  } room_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  // Input function codes
  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_OFFER = 1'b1;

  // Center of a span: start plus half the size, wrapping at 256
  function automatic logic [7:0] span_center(logic [7:0] pos, logic [7:0] size);
    span_center = pos + {1'b0, size[7:1]};
  endfunction

endpackage

// ----- src/rorf_room_mem.sv -----
`timescale 1ns / 1ps
module rorf_room_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  rorf_pkg::idx_t  waddr_i,
  input  rorf_pkg::room_t wdata_i,
  input  rorf_pkg::idx_t  raddr_i,
  output rorf_pkg::room_t rdata_o
);
  import rorf_pkg::*;

  room_t mem_q [MaxRoomSlots];
  room_t rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rorf_overlap_unit.sv -----
`timescale 1ns / 1ps
module rorf_overlap_unit (
  input  rorf_pkg::room_t cand_i,
  input  rorf_pkg::room_t entry_i,
  output logic            hit_o
);
  import rorf_pkg::*;

  // 9-bit sums: 255 + 255 + 1 never wraps
  logic [8:0] b_right, b_bottom, a_right, a_bottom;
  logic       x_hit, y_hit;

  assign b_right  = 9'(entry_i.x) + 9'(entry_i.w) + 9'd1;
  assign b_bottom = 9'(entry_i.y) + 9'(entry_i.h) + 9'd1;
  assign a_right  = 9'(cand_i.x) + 9'(cand_i.w) + 9'd1;
  assign a_bottom = 9'(cand_i.y) + 9'(cand_i.h) + 9'd1;

  // Inclusive test with a one-cell gap on each axis
  assign x_hit = (9'(cand_i.x) <= b_right) && (a_right >= 9'(entry_i.x));
  assign y_hit = (9'(cand_i.y) <= b_bottom) && (a_bottom >= 9'(entry_i.y));
  assign hit_o = x_hit && y_hit;

endmodule

// ----- src/room_overlap_rejection_filter_top.sv -----
`timescale 1ns / 1ps
// Room overlap rejection filter. A transaction is taken when start is high and busy is
// low; its single result appears one cycle on the result ports with result_valid_o
// high and cannot be held off, so the receiver must take it then. A clear, an offer
// against an empty table and an offer against a full table give their result in the
// cycle after start. An offer against stored rooms keeps busy high through its scan and
// shows its result as busy falls (sooner on an early overlap): one stored room is read
// from the room memory and checked by the shared overlap comparator each cycle. The
// room memory needs no clearing pass after reset.
module room_overlap_rejection_filter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       func_i,
  input  logic [7:0] cand_x_i,
  input  logic [7:0] cand_y_i,
  input  logic [7:0] cand_w_i,
  input  logic [7:0] cand_h_i,
  output logic       result_valid_o,
  output logic [1:0] status_o,
  output logic [6:0] new_index_o,
  output logic [6:0] conflict_index_o,
  output logic       has_previous_o,
  output logic [7:0] prev_center_x_o,
  output logic [7:0] prev_center_y_o,
  output logic [7:0] new_center_x_o,
  output logic [7:0] new_center_y_o
);
  import rorf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    status_e      status;
    logic [6:0]   new_index;
    logic [6:0]   conflict_index;
    logic         has_previous;
    logic [7:0]   prev_center_x;
    logic [7:0]   prev_center_y;
    logic [7:0]   new_center_x;
    logic [7:0]   new_center_y;
  } result_t;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  cnt_t    idx_q, idx_d;      // next slot to read
  idx_t    chk_q, chk_d;      // slot whose data sits on the read port
  logic    pend_q, pend_d;    // read data is valid for chk_q
  room_t   cand_q, cand_d;
  result_t res_q, res_d;
  logic    res_vld_q, res_vld_d;

  room_t   cand_in;
  room_t   rd_data;
  logic    hit;
  logic    mem_we;
  room_t   mem_wdata;
  idx_t    mem_raddr;

  assign cand_in = '{h: cand_h_i, w: cand_w_i, y: cand_y_i, x: cand_x_i};

  rorf_room_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  rorf_overlap_unit u_cmp (
    .cand_i  (cand_q),
    .entry_i (rd_data),
    .hit_o   (hit)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    chk_d     = chk_q;
    pend_d    = 1'b0;
    cand_d    = cand_q;
    res_d     = '0;
    res_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = cand_q;
    mem_raddr = idx_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cand_d = cand_in;
          if (func_i == FUNC_CLEAR) begin
            count_d      = '0;
            res_d.status = ST_CLEARED;
            res_vld_d    = 1'b1;
          end else if (count_q == cnt_t'(MaxRoomSlots)) begin
            res_d.status = ST_FULL;
            res_vld_d    = 1'b1;
          end else if (count_q == '0) begin
            // empty table: store into slot 0 straight away, no previous room
            mem_we             = 1'b1;
            mem_wdata          = cand_in;
            count_d            = cnt_t'(1);
            res_d.status       = ST_ACCEPT;
            res_d.new_center_x = span_center(cand_x_i, cand_w_i);
            res_d.new_center_y = span_center(cand_y_i, cand_h_i);
            res_vld_d          = 1'b1;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && hit) begin
          res_d.status         = ST_OVERLAP;
          res_d.conflict_index = OutIdxW'(chk_q);
          res_vld_d            = 1'b1;
          state_d              = S_IDLE;
        end else if (idx_q < count_q) begin
          pend_d = 1'b1;
          chk_d  = idx_q[IdxW-1:0];
          idx_d  = idx_q + cnt_t'(1);
        end else begin
          // last entry checked clean; it is also the previous room
          mem_we              = 1'b1;
          count_d             = count_q + cnt_t'(1);
          res_d.status        = ST_ACCEPT;
          res_d.new_index     = OutIdxW'(count_q);
          res_d.has_previous  = 1'b1;
          res_d.prev_center_x = span_center(rd_data.x, rd_data.w);
          res_d.prev_center_y = span_center(rd_data.y, rd_data.h);
          res_d.new_center_x  = span_center(cand_q.x, cand_q.w);
          res_d.new_center_y  = span_center(cand_q.y, cand_q.h);
          res_vld_d           = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      chk_q     <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      chk_q     <= chk_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    res_q  <= res_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = res_vld_q;
  assign status_o         = res_q.status;
  assign new_index_o      = res_q.new_index;
  assign conflict_index_o = res_q.conflict_index;
  assign has_previous_o   = res_q.has_previous;
  assign prev_center_x_o  = res_q.prev_center_x;
  assign prev_center_y_o  = res_q.prev_center_y;
  assign new_center_x_o   = res_q.new_center_x;
  assign new_center_y_o   = res_q.new_center_y;

endmodule
